FILE: rtl/core/c3vw_pkg.sv
// ----------------------------------------------------------------------------
// c3vw_pkg
// Shared widths, register indexes and types of the 3x3 valid-window
// convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package c3vw_pkg;

  localparam int PIX_W    = 16;   // signed Q8.8 pixel
  localparam int COEF_W   = 16;   // signed Q2.14 coefficient
  localparam int ROW_W    = 48;   // three packed coefficients
  localparam int PROD_W   = PIX_W + COEF_W;
  localparam int RSUM_W   = PROD_W + 2;
  localparam int SUM_W    = 35;   // nine products, 22 fractional bits
  localparam int POS_W    = 6;
  localparam int SIZE_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;
  localparam int WIN      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 3'd3;

  // Position tag that travels with a result through the pipeline.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } pos_t;

endpackage

`default_nettype wire

FILE: rtl/core/c3vw_if.sv
// ----------------------------------------------------------------------------
// c3vw channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface c3vw_pix_if;
  logic                                valid;
  logic                                ready;
  logic signed [c3vw_pkg::PIX_W-1:0]   pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface c3vw_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [c3vw_pkg::SUM_W-1:0]   conv_sum;
  logic        [c3vw_pkg::POS_W-1:0]   centre_row;
  logic        [c3vw_pkg::POS_W-1:0]   centre_col;
  logic                                frame_last;

  modport source (output valid, output conv_sum, output centre_row, output centre_col,
                  output frame_last, input ready);
  modport sink   (input valid, input conv_sum, input centre_row, input centre_col,
                  input frame_last, output ready);
endinterface

interface c3vw_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [c3vw_pkg::CFG_IDX_W-1:0]        index;
  logic [c3vw_pkg::CFG_DAT_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/conv3x3_valid_window.sv
// ----------------------------------------------------------------------------
// conv3x3_valid_window
// Streaming 3x3 convolution over a square image; one result per interior
// window centre, none on the border.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  pix_i   | in  | pixel                                     | valid/ready
//  res_o   | out | conv_sum, centre_row, centre_col, frame_last | valid/ready
//  cfg_i   | in  | index, data                               | valid/ready
//
// One pixel is accepted per clock while pix_i.ready is high. A result goes
// through the line store read, window, products, row sums and final sum
// registers to res_o; all stages move together. While the result register
// is full and not taken, pix_i.ready is low. Reset clears the pipeline valid
// bits, counters and coefficient registers; the line stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_valid_window #(
  parameter int MAX_IMAGE_SIZE = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  c3vw_pix_if.sink     pix_i,
  c3vw_res_if.source   res_o,
  c3vw_cfg_if.sink     cfg_i
);

  localparam int CW      = $clog2(MAX_IMAGE_SIZE);
  localparam int PixW    = c3vw_pkg::PIX_W;
  localparam int CoefW   = c3vw_pkg::COEF_W;
  localparam int ProdW   = c3vw_pkg::PROD_W;
  localparam int RsumW   = c3vw_pkg::RSUM_W;
  localparam int SumW    = c3vw_pkg::SUM_W;
  localparam int PosW    = c3vw_pkg::POS_W;
  localparam int RowW    = c3vw_pkg::ROW_W;
  localparam int Win     = c3vw_pkg::WIN;
  localparam int RstSize = (MAX_IMAGE_SIZE < 11) ? MAX_IMAGE_SIZE : 11;
  localparam logic [CW-1:0] RstLast = CW'(RstSize - 1);

  // Configuration registers.
  logic [RowW-1:0] coef_q [Win];
  logic [CW-1:0]   last_q;          // effective image size minus one
  logic [CW-1:0]   row_q, row_d;
  logic [CW-1:0]   col_q, col_d;

  logic            cfg_we;
  logic            size_we;
  logic [31:0]     size_req;
  logic [31:0]     size_eff;

  logic            advance;
  logic            accept;
  logic            produce;
  c3vw_pkg::pos_t  pos_now;

  // Line stores.
  logic [PixW-1:0] older_mem [MAX_IMAGE_SIZE];
  logic [PixW-1:0] newer_mem [MAX_IMAGE_SIZE];

  // Stage 1: line store read data and the accepted pixel.
  logic            s1_valid_q;
  logic            s1_prod_q;
  logic [PixW-1:0] s1_pix_q;
  logic [PixW-1:0] rd_old_q;
  logic [PixW-1:0] rd_new_q;
  logic [CW-1:0]   s1_col_q;
  c3vw_pkg::pos_t  s1_pos_q;

  // Stage 2: window.
  logic                    v2_q;
  logic signed [PixW-1:0]  win_q [Win][Win];
  c3vw_pkg::pos_t          s2_pos_q;

  // Stage 3: products.
  logic                    v3_q;
  logic signed [ProdW-1:0] prod_q [Win][Win];
  c3vw_pkg::pos_t          s3_pos_q;

  // Stage 4: row sums.
  logic                    v4_q;
  logic signed [RsumW-1:0] rsum_q [Win];
  c3vw_pkg::pos_t          s4_pos_q;

  // Result register.
  logic                    out_valid_q;
  logic signed [SumW-1:0]  out_sum_q;
  c3vw_pkg::pos_t          out_pos_q;

  assign advance     = !out_valid_q || res_o.ready;
  assign accept      = pix_i.valid && advance;
  assign pix_i.ready = advance;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign size_we     = cfg_we && (cfg_i.index == c3vw_pkg::CFG_IMAGE_SIZE);

  // Out-of-range sizes are clamped to 3 .. MAX_IMAGE_SIZE.
  always_comb begin
    size_req = {25'd0, cfg_i.data[c3vw_pkg::SIZE_W-1:0]};
    if (size_req < 32'd3) begin
      size_eff = 32'd3;
    end else if (size_req > 32'(MAX_IMAGE_SIZE)) begin
      size_eff = 32'(MAX_IMAGE_SIZE);
    end else begin
      size_eff = size_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < Win; m++) begin
        coef_q[m] <= '0;
      end
      last_q <= RstLast;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        c3vw_pkg::CFG_COEF_TOP:    coef_q[0] <= cfg_i.data;
        c3vw_pkg::CFG_COEF_MIDDLE: coef_q[1] <= cfg_i.data;
        c3vw_pkg::CFG_COEF_BOTTOM: coef_q[2] <= cfg_i.data;
        c3vw_pkg::CFG_IMAGE_SIZE:  last_q <= CW'(size_eff - 32'd1);
        default: begin
        end
      endcase
    end
  end

  // Raster position of the incoming pixel.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (size_we) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (col_q == last_q) begin
        col_d = '0;
        row_d = (row_q == last_q) ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign produce      = (row_q >= CW'(2)) && (col_q >= CW'(2));
  assign pos_now.row  = PosW'(row_q - CW'(1));
  assign pos_now.col  = PosW'(col_q - CW'(1));
  assign pos_now.last = (row_q == last_q) && (col_q == last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_prod_q   <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (advance) begin
        s1_valid_q  <= accept;
        s1_prod_q   <= accept && produce;
        v2_q        <= s1_prod_q;
        v3_q        <= v2_q;
        v4_q        <= v3_q;
        out_valid_q <= v4_q;
      end
    end
  end

  // The newer store is read and rewritten when a pixel is accepted; the
  // older store takes the newer store's old entry once that item leaves
  // stage 1, well before the same column comes around again.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_old_q         <= older_mem[col_q];
      rd_new_q         <= newer_mem[col_q];
      newer_mem[col_q] <= pix_i.pixel;
      s1_pix_q         <= pix_i.pixel;
      s1_col_q         <= col_q;
      s1_pos_q         <= pos_now;
    end
    if (s1_valid_q && advance) begin
      older_mem[s1_col_q] <= rd_new_q;
    end
  end

  // Datapath: window shift, products, row sums, final sum.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (s1_valid_q) begin
        for (int m = 0; m < Win; m++) begin
          win_q[m][0] <= win_q[m][1];
          win_q[m][1] <= win_q[m][2];
        end
        win_q[0][2] <= $signed(rd_old_q);
        win_q[1][2] <= $signed(rd_new_q);
        win_q[2][2] <= $signed(s1_pix_q);
      end
      s2_pos_q <= s1_pos_q;

      for (int m = 0; m < Win; m++) begin
        for (int n = 0; n < Win; n++) begin
          prod_q[m][n] <= win_q[m][n] * $signed(coef_q[m][CoefW*n +: CoefW]);
        end
      end
      s3_pos_q <= s2_pos_q;

      for (int m = 0; m < Win; m++) begin
        rsum_q[m] <= RsumW'(prod_q[m][0]) + RsumW'(prod_q[m][1]) + RsumW'(prod_q[m][2]);
      end
      s4_pos_q <= s3_pos_q;

      out_sum_q <= SumW'(rsum_q[0]) + SumW'(rsum_q[1]) + SumW'(rsum_q[2]);
      out_pos_q <= s4_pos_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.conv_sum   = out_sum_q;
  assign res_o.centre_row = out_pos_q.row;
  assign res_o.centre_col = out_pos_q.col;
  assign res_o.frame_last = out_pos_q.last;

endmodule

`default_nettype wire

FILE: rtl/core/c3vw_checker.sv
// ----------------------------------------------------------------------------
// c3vw_checker
// Port-level checks on the convolution block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module c3vw_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               pix_ready_i,
  input wire                               res_valid_i,
  input wire                               res_ready_i,
  input wire [c3vw_pkg::SUM_W-1:0]         res_sum_i,
  input wire [c3vw_pkg::POS_W-1:0]         res_row_i,
  input wire [c3vw_pkg::POS_W-1:0]         res_col_i,
  input wire                               res_last_i
);

  // A stalled result keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_sum_i)
      && $stable(res_row_i) && $stable(res_col_i) && $stable(res_last_i))
    else $error("result changed while stalled");

  // A full result register that is not taken holds back the pixel input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |-> !pix_ready_i)
    else $error("pixel accepted while pipeline stalled");

  // With the result register empty nothing can stall the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> pix_ready_i)
    else $error("pixel input blocked with empty result register");

  // The final centre of a square image lies on the diagonal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_last_i |-> res_row_i == res_col_i)
    else $error("frame end flagged off the diagonal");

endmodule

bind conv3x3_valid_window c3vw_checker u_c3vw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_sum_i   (res_o.conv_sum),
  .res_row_i   (res_o.centre_row),
  .res_col_i   (res_o.centre_col),
  .res_last_i  (res_o.frame_last)
);

`default_nettype wire

FILE: dv/tb_conv3x3_valid_window.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conv3x3_valid_window
// Streams square images through the 3x3 valid-window convolution with random
// gaps on the pixel side and random stalls on the result side. Each result is
// checked against a cycle-free prediction kept in the testbench. Register
// writes happen only while the block is drained.
// ----------------------------------------------------------------------------
module tb_conv3x3_valid_window;

  localparam int MAX_SIDE      = 64;
  localparam int SIDE_AT_RESET = 11;
  localparam int TAIL_CYCLES   = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 1050;
  localparam int REPORT_LIMIT  = 10;

  // Indexes past the image size register decode to nothing.
  localparam logic [c3vw_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd4;

  localparam logic [15:0] MOST_NEG_16 = 16'h8000;
  localparam logic [15:0] MOST_POS_16 = 16'h7FFF;

  typedef struct packed {
    logic [c3vw_pkg::SUM_W-1:0] conv_sum;
    c3vw_pkg::pos_t             pos;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  c3vw_pix_if pix_ch ();
  c3vw_res_if res_ch ();
  c3vw_cfg_if cfg_ch ();

  conv3x3_valid_window #(
    .MAX_IMAGE_SIZE(MAX_SIDE)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted block state.
  logic [c3vw_pkg::ROW_W-1:0]        coef_rows [c3vw_pkg::WIN];
  logic [c3vw_pkg::SIZE_W-1:0]       side_reg;
  logic signed [c3vw_pkg::PIX_W-1:0] older_row [MAX_SIDE];
  logic signed [c3vw_pkg::PIX_W-1:0] newer_row [MAX_SIDE];
  logic signed [c3vw_pkg::PIX_W-1:0] win_px    [c3vw_pkg::WIN][c3vw_pkg::WIN];
  int                                next_row;
  int                                next_col;

  conv_result_t               pending_sums [$];
  logic [c3vw_pkg::PIX_W-1:0] pixel_q      [$];
  conv_result_t               want;

  int mismatches   = 0;
  int quiet_cycles = 0;
  int pix_gap;
  int res_stall;
  bit pix_calm     = 1'b0;
  bit res_calm     = 1'b0;

  function automatic int effective_side(input logic [c3vw_pkg::SIZE_W-1:0] raw);
    if (raw < c3vw_pkg::WIN) return c3vw_pkg::WIN;
    if (raw > MAX_SIDE) return MAX_SIDE;
    return int'(raw);
  endfunction

  function automatic int pause_length(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly random, with the extremes and the values around zero drawn often.
  function automatic logic [15:0] random_q16();
    case ($urandom_range(0, 19))
      0:       return MOST_NEG_16;
      1:       return MOST_POS_16;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void apply_reg_write(input logic [c3vw_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [c3vw_pkg::CFG_DAT_W-1:0] value);
    case (idx)
      c3vw_pkg::CFG_COEF_TOP:    coef_rows[0] = value[c3vw_pkg::ROW_W-1:0];
      c3vw_pkg::CFG_COEF_MIDDLE: coef_rows[1] = value[c3vw_pkg::ROW_W-1:0];
      c3vw_pkg::CFG_COEF_BOTTOM: coef_rows[2] = value[c3vw_pkg::ROW_W-1:0];
      c3vw_pkg::CFG_IMAGE_SIZE: begin
        side_reg = value[c3vw_pkg::SIZE_W-1:0];
        next_row = 0;
        next_col = 0;
      end
      default: ;
    endcase
  endfunction

  // Shifts one pixel into the line stores and the window, and queues the
  // expected sum when the window centre is interior.
  function automatic void convolve_pixel(input logic signed [c3vw_pkg::PIX_W-1:0] px);
    int                                 side;
    logic signed [63:0]                 acc;
    logic signed [63:0]                 px64;
    logic signed [63:0]                 k64;
    logic signed [c3vw_pkg::COEF_W-1:0] k;
    conv_result_t                       res;
    side = effective_side(side_reg);
    for (int m = 0; m < c3vw_pkg::WIN; m++) begin
      win_px[m][0] = win_px[m][1];
      win_px[m][1] = win_px[m][2];
    end
    win_px[0][2] = older_row[next_col];
    win_px[1][2] = newer_row[next_col];
    win_px[2][2] = px;
    older_row[next_col] = newer_row[next_col];
    newer_row[next_col] = px;
    if (next_row >= 2 && next_col >= 2) begin
      acc = '0;
      for (int m = 0; m < c3vw_pkg::WIN; m++) begin
        for (int n = 0; n < c3vw_pkg::WIN; n++) begin
          k    = coef_rows[m][c3vw_pkg::COEF_W*n +: c3vw_pkg::COEF_W];
          px64 = win_px[m][n];
          k64  = k;
          acc  = acc + px64 * k64;
        end
      end
      res.conv_sum = acc[c3vw_pkg::SUM_W-1:0];
      res.pos.row  = c3vw_pkg::POS_W'(next_row - 1);
      res.pos.col  = c3vw_pkg::POS_W'(next_col - 1);
      res.pos.last = (next_row == side - 1) && (next_col == side - 1);
      pending_sums.push_back(res);
    end
    if (next_col + 1 >= side) begin
      next_col = 0;
      next_row = (next_row + 1 >= side) ? 0 : next_row + 1;
    end else begin
      next_col = next_col + 1;
    end
  endfunction

  // Pixel driver: one request per accepted handshake, gaps drawn per item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_ch.valid <= 1'b0;
      pix_ch.pixel <= '0;
      pix_gap      <= 0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (pix_gap > 0) begin
        pix_ch.valid <= 1'b0;
        pix_gap      <= pix_gap - 1;
      end else if (pixel_q.size() != 0) begin
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= pixel_q.pop_front();
        pix_gap      <= pause_length(pix_calm);
        if ($urandom_range(0, 299) == 0) pix_calm <= !pix_calm;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      res_stall    <= 0;
    end else begin
      if (res_stall > 0) begin
        res_ch.ready <= 1'b0;
        res_stall    <= res_stall - 1;
      end else begin
        res_ch.ready <= 1'b1;
        res_stall    <= pause_length(res_calm);
      end
      if ($urandom_range(0, 499) == 0) res_calm <= !res_calm;
    end
  end

  // Monitor: follows register writes and pixel requests, checks results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < c3vw_pkg::WIN; m++) begin
        coef_rows[m] = '0;
        for (int n = 0; n < c3vw_pkg::WIN; n++) win_px[m][n] = '0;
      end
      for (int c = 0; c < MAX_SIDE; c++) begin
        older_row[c] = '0;
        newer_row[c] = '0;
      end
      side_reg = c3vw_pkg::SIZE_W'(SIDE_AT_RESET);
      next_row = 0;
      next_col = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg_write(cfg_ch.index, cfg_ch.data);
      if (pix_ch.valid && pix_ch.ready) convolve_pixel(pix_ch.pixel);
      if (res_ch.valid && res_ch.ready) begin
        if (pending_sums.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected result sum %0d row %0d col %0d last %0b", $realtime,
                     res_ch.conv_sum, res_ch.centre_row, res_ch.centre_col,
                     res_ch.frame_last);
          mismatches++;
        end else begin
          want = pending_sums.pop_front();
          if (res_ch.conv_sum !== want.conv_sum || res_ch.centre_row !== want.pos.row ||
              res_ch.centre_col !== want.pos.col || res_ch.frame_last !== want.pos.last) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: expected sum %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                       $realtime, $signed(want.conv_sum), want.pos.row, want.pos.col,
                       want.pos.last, res_ch.conv_sum, res_ch.centre_row,
                       res_ch.centre_col, res_ch.frame_last);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [c3vw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [c3vw_pkg::CFG_DAT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every pixel is taken and every result checked, then lets the
  // pipeline empty of border pixels that produce nothing.
  task automatic wait_for_idle();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || pix_ch.valid || pending_sums.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int                             side;
    int                             count;
    int                             roll;
    int                             random_items;
    logic [c3vw_pkg::SIZE_W-1:0]    raw_side;
    logic [c3vw_pkg::CFG_DAT_W-1:0] cfg_word;

    rst_ni       = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // Largest positive sum, at the image size left by reset.
    write_reg(c3vw_pkg::CFG_COEF_TOP, c3vw_pkg::CFG_DAT_W'({3{MOST_NEG_16}}));
    write_reg(c3vw_pkg::CFG_COEF_MIDDLE, c3vw_pkg::CFG_DAT_W'({3{MOST_NEG_16}}));
    write_reg(c3vw_pkg::CFG_COEF_BOTTOM, c3vw_pkg::CFG_DAT_W'({3{MOST_NEG_16}}));
    for (int i = 0; i < 2 * SIDE_AT_RESET + c3vw_pkg::WIN; i++)
      pixel_q.push_back(MOST_NEG_16);
    wait_for_idle();

    // Size written mid-frame and below the minimum; most negative sum.
    write_reg(c3vw_pkg::CFG_COEF_TOP, c3vw_pkg::CFG_DAT_W'({3{MOST_POS_16}}));
    write_reg(c3vw_pkg::CFG_COEF_MIDDLE, c3vw_pkg::CFG_DAT_W'({3{MOST_POS_16}}));
    write_reg(c3vw_pkg::CFG_COEF_BOTTOM, c3vw_pkg::CFG_DAT_W'({3{MOST_POS_16}}));
    write_reg(c3vw_pkg::CFG_IMAGE_SIZE, c3vw_pkg::CFG_DAT_W'(2));
    for (int i = 0; i < c3vw_pkg::WIN * c3vw_pkg::WIN; i++) pixel_q.push_back(MOST_NEG_16);
    wait_for_idle();
    write_reg(CFG_IDX_SPARE, '1);

    // Widest image, with junk above the size field; the frame is left
    // unfinished after it has reached the last interior column.
    cfg_word = c3vw_pkg::CFG_DAT_W'({$urandom, $urandom});
    cfg_word[c3vw_pkg::SIZE_W-1:0] = c3vw_pkg::SIZE_W'(MAX_SIDE);
    write_reg(c3vw_pkg::CFG_IMAGE_SIZE, cfg_word);
    side = MAX_SIDE;
    count = c3vw_pkg::WIN * MAX_SIDE + $urandom_range(0, 20);
    for (int i = 0; i < count; i++) pixel_q.push_back(random_q16());
    random_items = count;

    while (random_items < RANDOM_PIXELS) begin
      wait_for_idle();
      if ($urandom_range(0, 99) < 40)
        write_reg(c3vw_pkg::CFG_COEF_TOP, c3vw_pkg::CFG_DAT_W'({3{random_q16()}}));
      if ($urandom_range(0, 99) < 40)
        write_reg(c3vw_pkg::CFG_COEF_MIDDLE,
                  c3vw_pkg::CFG_DAT_W'({random_q16(), random_q16(), random_q16()}));
      if ($urandom_range(0, 99) < 40)
        write_reg(c3vw_pkg::CFG_COEF_BOTTOM,
                  c3vw_pkg::CFG_DAT_W'({random_q16(), random_q16(), random_q16()}));
      if ($urandom_range(0, 99) < 8)
        write_reg(CFG_IDX_SPARE + c3vw_pkg::CFG_IDX_W'($urandom_range(0, 3)),
                  c3vw_pkg::CFG_DAT_W'({$urandom, $urandom}));
      if ($urandom_range(0, 99) < 80) begin
        roll = $urandom_range(0, 99);
        if (roll < 70)      raw_side = c3vw_pkg::SIZE_W'($urandom_range(3, 10));
        else if (roll < 82) raw_side = c3vw_pkg::SIZE_W'($urandom_range(0, 2));
        else if (roll < 92) raw_side = c3vw_pkg::SIZE_W'($urandom_range(11, 24));
        else                raw_side = c3vw_pkg::SIZE_W'($urandom_range(MAX_SIDE, 127));
        cfg_word = c3vw_pkg::CFG_DAT_W'({$urandom, $urandom});
        cfg_word[c3vw_pkg::SIZE_W-1:0] = raw_side;
        write_reg(c3vw_pkg::CFG_IMAGE_SIZE, cfg_word);
        side = effective_side(raw_side);
        // Large images only get a partial frame to keep the run short.
        if (side > 12) begin
          count = $urandom_range(1, c3vw_pkg::WIN * side);
        end else begin
          count = side * side * $urandom_range(1, 3);
          if ($urandom_range(0, 3) == 0) count += $urandom_range(1, side * side - 1);
        end
      end else begin
        // No size write: the current frame simply goes on.
        count = $urandom_range(1, c3vw_pkg::WIN * side);
      end
      for (int i = 0; i < count; i++) pixel_q.push_back(random_q16());
      random_items += count;
    end

    wait_for_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
